[rtl/core/sbpad_pkg.sv]
// Shared types and constants for the six-button pad poll sequencer.
package sbpad_pkg;

  localparam int PhaseWidth = 5;
  localparam int WordWidth  = 12;
  localparam int RptWidth   = 8;
  localparam int AxisWidth  = 8;

  localparam logic [PhaseWidth-1:0] LastPhase   = 5'd16;
  localparam int                    ReportShift = 4;

  localparam logic signed [AxisWidth-1:0] AxisNeg  = -8'sd128;
  localparam logic signed [AxisWidth-1:0] AxisPos  = 8'sd127;
  localparam logic signed [AxisWidth-1:0] AxisZero = 8'sd0;

  localparam logic OpStart = 1'b0;
  localparam logic OpTick  = 1'b1;

  localparam int BRight = 0;
  localparam int BLeft  = 1;
  localparam int BDown  = 2;
  localparam int BUp    = 3;
  localparam int BMode  = 4;
  localparam int BStart = 5;
  localparam int BZ     = 6;
  localparam int BY     = 7;
  localparam int BX     = 8;
  localparam int BC     = 9;
  localparam int BB     = 10;
  localparam int BA     = 11;

  typedef struct packed {
    logic                        select_level;
    logic                        report_valid;
    logic [RptWidth-1:0]         report_buttons;
    logic signed [AxisWidth-1:0] axis_x;
    logic signed [AxisWidth-1:0] axis_y;
    logic                        led_on;
    logic                        busy_res;
  } res_t;

  function automatic logic signed [AxisWidth-1:0] axis_of(input logic neg, input logic pos);
    logic signed [AxisWidth-1:0] a;
    a = AxisZero;
    if (neg && !pos) a = AxisNeg;
    if (pos && !neg) a = AxisPos;
    return a;
  endfunction

endpackage

[rtl/core/six_button_pad_poll_sequencer_top.sv]
// Top level of the six-button pad poll sequencer: phase state, latching and output buffer.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------------
//  in      | in_valid / in_stall  | op, pad_pin1..4, pad_pin6, pad_pin9
//  out     | out_valid / out_stall| select_level, report_valid, report_buttons, axis_x,
//          |                      | axis_y, led_on, busy_res
//
// One transaction per cycle while in_stall is low; each result is registered.
// Frame state and the result are computed in one pass from the state registers.
// A two-entry output buffer (result register plus skid) keeps input flowing while the
// output stalls until the skid fills; in_stall rises only when the skid entry is occupied.
// rst is synchronous and clears phase, select, running, button word and both buffers.
module six_button_pad_poll_sequencer_top
  import sbpad_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic                        pad_pin1,
  input  logic                        pad_pin2,
  input  logic                        pad_pin3,
  input  logic                        pad_pin4,
  input  logic                        pad_pin6,
  input  logic                        pad_pin9,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        select_level,
  output logic                        report_valid,
  output logic [RptWidth-1:0]         report_buttons,
  output logic signed [AxisWidth-1:0] axis_x,
  output logic signed [AxisWidth-1:0] axis_y,
  output logic                        led_on,
  output logic                        busy_res
);

  logic [PhaseWidth-1:0] phase_count, phase_count_next;
  logic                  select_flag, select_flag_next;
  logic                  running, running_next;
  logic [WordWidth-1:0]  button_word, button_word_next;

  res_t res_new;
  res_t out_res;
  res_t skid_res;
  logic skid_valid;
  logic accept;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    phase_count_next = phase_count;
    select_flag_next = select_flag;
    running_next     = running;
    button_word_next = button_word;
    res_new          = '0;
    if (op == OpStart) begin
      select_flag_next = 1'b1;
      running_next     = 1'b1;
    end else if (running) begin
      if (phase_count[0]) select_flag_next = !select_flag;
      case (phase_count)
        5'd0, 5'd4, 5'd8: begin
          button_word_next[BUp]    = pad_pin1;
          button_word_next[BDown]  = pad_pin2;
          button_word_next[BLeft]  = pad_pin3;
          button_word_next[BRight] = pad_pin4;
          button_word_next[BB]     = pad_pin6;
          button_word_next[BC]     = pad_pin9;
        end
        5'd2, 5'd6: begin
          button_word_next[BUp]    = pad_pin1;
          button_word_next[BDown]  = pad_pin2;
          button_word_next[BA]     = pad_pin6;
          button_word_next[BStart] = pad_pin9;
        end
        5'd10, 5'd14: begin
          button_word_next[BA]     = pad_pin6;
          button_word_next[BStart] = pad_pin9;
        end
        5'd12: begin
          button_word_next[BZ]     = pad_pin1;
          button_word_next[BY]     = pad_pin2;
          button_word_next[BX]     = pad_pin3;
          button_word_next[BMode]  = pad_pin4;
          button_word_next[BB]     = pad_pin6;
          button_word_next[BC]     = pad_pin9;
        end
        default: begin
        end
      endcase
      if (phase_count == LastPhase) begin
        phase_count_next       = '0;
        running_next           = 1'b0;
        res_new.report_valid   = 1'b1;
        res_new.led_on         = |button_word_next;
        res_new.axis_y         = axis_of(button_word_next[BUp], button_word_next[BDown]);
        res_new.axis_x         = axis_of(button_word_next[BLeft], button_word_next[BRight]);
        res_new.report_buttons = button_word_next[ReportShift +: RptWidth];
      end else begin
        phase_count_next = phase_count + 1'b1;
      end
    end
    res_new.select_level = select_flag_next;
    res_new.busy_res     = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      select_flag <= 1'b0;
      running     <= 1'b0;
      button_word <= '0;
    end else if (accept) begin
      phase_count <= phase_count_next;
      select_flag <= select_flag_next;
      running     <= running_next;
      button_word <= button_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) out_res <= res_new;
      end
    end else if (accept) begin
      skid_res   <= res_new;
      skid_valid <= 1'b1;
    end
  end

  assign select_level   = out_res.select_level;
  assign report_valid   = out_res.report_valid;
  assign report_buttons = out_res.report_buttons;
  assign axis_x         = out_res.axis_x;
  assign axis_y         = out_res.axis_y;
  assign led_on         = out_res.led_on;
  assign busy_res       = out_res.busy_res;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_count <= LastPhase)
    else $error("phase counter past last phase");

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty result register");

  a_report_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid |-> !busy_res)
    else $error("report while frame still running");

  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid |-> report_buttons == '0 && axis_x == AxisZero &&
      axis_y == AxisZero && !led_on)
    else $error("report fields set without a report");
`endif

endmodule

[bench/tb_six_button_pad_poll_sequencer_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the six-button pad poll sequencer with random handshake idling.
module tb_six_button_pad_poll_sequencer_top;
  import sbpad_pkg::*;

  typedef struct packed {
    logic       op;
    logic [5:0] pins;  // p1 p2 p3 p4 p6 p9, msb first
    logic       hold;  // sender waits for all results before this item
  } pad_item_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        op = OpTick;
  logic                        pad_pin1 = 1'b0;
  logic                        pad_pin2 = 1'b0;
  logic                        pad_pin3 = 1'b0;
  logic                        pad_pin4 = 1'b0;
  logic                        pad_pin6 = 1'b0;
  logic                        pad_pin9 = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        select_level;
  logic                        report_valid;
  logic [RptWidth-1:0]         report_buttons;
  logic signed [AxisWidth-1:0] axis_x;
  logic signed [AxisWidth-1:0] axis_y;
  logic                        led_on;
  logic                        busy_res;

  six_button_pad_poll_sequencer_top dut (.*);

  always #5 clk = ~clk;

  pad_item_t pend_items[$];
  res_t      pad_res_q[$];
  pad_item_t cur;

  // predictor state
  logic [PhaseWidth-1:0] phase = '0;
  logic                  sel = 1'b0;
  logic                  run = 1'b0;
  logic [WordWidth-1:0]  word = '0;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_reports = 0;
  int n_restarts = 0;
  int n_idle_ticks = 0;
  int n_cancel = 0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cyc = 0;
  bit tail_run = 1'b0;

  task automatic pad_step(input pad_item_t it);
    res_t r;
    logic p1, p2, p3, p4, p6, p9;
    {p1, p2, p3, p4, p6, p9} = it.pins;
    r = '0;
    if (it.op == OpStart) begin
      if (run) n_restarts++;
      sel = 1'b1;
      run = 1'b1;
    end else if (!run) begin
      n_idle_ticks++;
    end else begin
      if (phase[0]) sel = ~sel;
      case (phase)
        5'd0, 5'd4, 5'd8: begin
          word[BUp] = p1; word[BDown] = p2; word[BLeft] = p3; word[BRight] = p4;
          word[BB] = p6; word[BC] = p9;
        end
        5'd2, 5'd6: begin
          word[BUp] = p1; word[BDown] = p2; word[BA] = p6; word[BStart] = p9;
        end
        5'd10, 5'd14: begin
          word[BA] = p6; word[BStart] = p9;
        end
        5'd12: begin
          word[BZ] = p1; word[BY] = p2; word[BX] = p3; word[BMode] = p4;
          word[BB] = p6; word[BC] = p9;
        end
        default: ;
      endcase
      phase = phase + 1'b1;
      if (phase > LastPhase) begin
        phase = '0;
        run = 1'b0;
        n_reports++;
        if ((word[BUp] && word[BDown]) || (word[BLeft] && word[BRight])) n_cancel++;
        r.report_valid = 1'b1;
        r.led_on = |word;
        r.report_buttons = RptWidth'(word >> ReportShift);
        r.axis_x = (word[BLeft] && !word[BRight]) ? AxisNeg :
                   (word[BRight] && !word[BLeft]) ? AxisPos : AxisZero;
        r.axis_y = (word[BUp] && !word[BDown]) ? AxisNeg :
                   (word[BDown] && !word[BUp]) ? AxisPos : AxisZero;
      end
    end
    r.select_level = sel;
    r.busy_res = run;
    pad_res_q.push_back(r);
  endtask

  task automatic check_field(input string nm, input logic [7:0] e, input logic [7:0] a);
    if (a !== e) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, nm, e, a);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pad_step(cur);
        n_in++;
      end
      tail_run = pend_items.size() < 120;
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pend_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pend_items[0].hold && pad_res_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!tail_run && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else begin
          cur = pend_items.pop_front();
          in_valid <= 1'b1;
          op <= cur.op;
          {pad_pin1, pad_pin2, pad_pin3, pad_pin4, pad_pin6, pad_pin9} <= cur.pins;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pad_res_q.size() == 0) begin
          $display("%0t ns: unexpected transaction, expected none, actual %h", $time,
                   {select_level, report_valid, report_buttons, axis_x, axis_y, led_on,
                    busy_res});
          errors++;
        end else begin
          e = pad_res_q.pop_front();
          n_out++;
          check_field("select_level", 8'(e.select_level), 8'(select_level));
          check_field("report_valid", 8'(e.report_valid), 8'(report_valid));
          check_field("report_buttons", e.report_buttons, report_buttons);
          check_field("axis_x", e.axis_x, axis_x);
          check_field("axis_y", e.axis_y, axis_y);
          check_field("led_on", 8'(e.led_on), 8'(led_on));
          check_field("busy_res", 8'(e.busy_res), 8'(busy_res));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!tail_run && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= 2000) begin
        $display("watchdog: no transaction for %0d cycles", idle_cyc);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic add_item(input logic o, input logic [5:0] p, input logic h = 1'b0);
    pad_item_t it;
    it.op = o;
    it.pins = p;
    it.hold = h;
    pend_items.push_back(it);
  endtask

  initial begin
    int kind;
    int pm;
    logic [5:0] fixed_pins;
    logic [5:0] p;
    bit held;
    held = 1'b0;

    // directed: ignored tick, full frame with restart mid-frame, all held, then up+left
    add_item(OpTick, 6'h3f);
    add_item(OpStart, 6'h00);
    for (int ph = 0; ph <= 16; ph++) begin
      if (ph == 5) add_item(OpStart, 6'h3f);
      add_item(OpTick, (ph == 8) ? 6'b101011 : 6'h3f);
    end
    add_item(OpTick, 6'h00);

    while (pend_items.size() < 950) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4))
          add_item(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
      end else begin
        add_item(OpStart, 6'($urandom_range(0, 63)),
                 !held && pend_items.size() > 400);
        if (pend_items.size() > 400) held = 1'b1;
        pm = $urandom_range(0, 3);
        fixed_pins = 6'($urandom_range(0, 63));
        for (int ph = 0; ph <= 16; ph++) begin
          case (pm)
            0: p = 6'h00;
            1: p = 6'h3f;
            2: p = 6'($urandom_range(0, 63));
            default: p = fixed_pins;
          endcase
          if ($urandom_range(0, 40) == 0) add_item(OpStart, 6'($urandom_range(0, 63)));
          if ($urandom_range(0, 60) == 0) break;
          add_item(OpTick, p);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pend_items.size() != 0 || in_valid || pad_res_q.size() != 0);
    repeat (10) @(posedge clk);
    if (pad_res_q.size() != 0) begin
      $display("%0t ns: %0d expected transactions never arrived", $time, pad_res_q.size());
      errors++;
    end
    $display("Sent %0d items, checked %0d results: %0d frame reports, %0d with cancelled axes,",
             n_in, n_out, n_reports, n_cancel);
    $display("%0d restarts while running, %0d ticks while idle, %0d mismatches.",
             n_restarts, n_idle_ticks, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[six_button_pad_poll_sequencer_top.f]
rtl/core/sbpad_pkg.sv
rtl/core/six_button_pad_poll_sequencer_top.sv
bench/tb_six_button_pad_poll_sequencer_top.sv
